// ----- sv/cwnf_pkg.sv -----
// Shared types, constants and state encodings of the circular window note filter.
package cwnf_pkg;
	localparam int TICK_BITS  = 24;
	localparam int TAG_BITS   = 16;
	localparam int PROBE_STEP = 24;
	localparam int MW         = TICK_BITS + 2;
	localparam int CNT_BITS   = $clog2(MW + 1);
	localparam int QDEPTH     = 2;
	localparam int QPTR_BITS  = 1;
	localparam int QCNT_BITS  = 2;

	// reciprocal of the probe step, exact for any MW-bit dividend
	localparam int PROBE_SHIFT = MW + $clog2(PROBE_STEP);
	localparam logic [MW:0] PROBE_RECIP = (MW+1)'(((64'd1 << PROBE_SHIFT) +
		64'(PROBE_STEP) - 64'd1) / 64'(PROBE_STEP));

	typedef logic [TICK_BITS-1:0] tick_t;
	typedef logic [MW-1:0]        wide_t;
	typedef logic [TAG_BITS-1:0]  tag_t;

	typedef enum logic [1:0] {
		CFG_LOOP   = 2'd0,
		CFG_WSTART = 2'd1,
		CFG_WLEN   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		tick_t loop_len;
		tick_t win_start;
		tick_t win_len;
	} cfg_t;

	typedef struct packed {
		tick_t ns;
		tick_t ne;
		tag_t  tag;
		tick_t s;
		tick_t e;
		tick_t a;
		logic  pass;
	} note_ent_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WIN,
		B_MOD,
		B_OUT
	} back_state_t;
endpackage

// ----- sv/cwnf_mod.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module cwnf_mod (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cwnf_pkg::wide_t num,
	input  cwnf_pkg::wide_t den,
	output logic          done,
	output cwnf_pkg::wide_t rem
);
	import cwnf_pkg::*;

	wide_t               num_q, den_q, rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [MW:0]         trial;
	logic [MW:0]         diff;

	// form the next partial remainder
	always_comb begin
		trial = {rem_q, num_q[MW-1]};
		diff  = trial - {1'b0, den_q};
	end

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_BITS'(1));
			if (start)
				cnt_q <= CNT_BITS'(MW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	// datapath: shift dividend, subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[MW-2:0], 1'b0};
			if (trial >= {1'b0, den_q})
				rem_q <= diff[MW-1:0];
			else
				rem_q <= trial[MW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ----- sv/cwnf_front.sv -----
// Front end: accept notes, classify them and reduce ticks modulo the loop length.
module cwnf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  cwnf_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  cwnf_pkg::tick_t     note_start,
	input  cwnf_pkg::tick_t     note_end,
	input  cwnf_pkg::tag_t      note_tag,
	output logic                push,
	output cwnf_pkg::note_ent_t push_ent,
	input  logic                q_full
);
	import cwnf_pkg::*;

	front_state_t state_q, state_d;
	logic [1:0]   idx_q;
	note_ent_t    ent_q;
	logic         accept, drop_all, pass_all;
	logic         mod_start, mod_done;
	wide_t        mod_num, mod_rem;

	assign accept   = in_valid && !in_stall;
	assign drop_all = (cfg.loop_len == '0) || (cfg.win_len == '0);
	assign pass_all = cfg.win_len >= cfg.loop_len;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept && !drop_all)
					state_d = pass_all ? F_PUSH : F_MOD;
			end
			F_MOD: begin
				if (mod_done && idx_q == 2'd2)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = 1'b1;
		push      = 1'b0;
		mod_start = 1'b0;
		mod_num   = {2'b00, ent_q.ns};
		case (state_q)
			F_IDLE: begin
				in_stall  = 1'b0;
				mod_start = accept && !drop_all && !pass_all;
				mod_num   = {2'b00, note_start};
			end
			F_MOD: begin
				mod_start = mod_done && idx_q != 2'd2;
				mod_num   = (idx_q == 2'd0) ? {2'b00, ent_q.ne} : {2'b00, cfg.win_start};
			end
			F_PUSH: push = !q_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (accept)
				idx_q <= 2'd0;
			else if (state_q == F_MOD && mod_done)
				idx_q <= idx_q + 2'd1;
		end
	end

	// hold the request and store reduced ticks
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q.ns   <= note_start;
			ent_q.ne   <= note_end;
			ent_q.tag  <= note_tag;
			ent_q.pass <= pass_all;
		end else if (state_q == F_MOD && mod_done) begin
			case (idx_q)
				2'd0:    ent_q.s <= mod_rem[TICK_BITS-1:0];
				2'd1:    ent_q.e <= mod_rem[TICK_BITS-1:0];
				default: ent_q.a <= mod_rem[TICK_BITS-1:0];
			endcase
		end
	end

	cwnf_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.num    (mod_num),
		.den    ({2'b00, cfg.loop_len}),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	assign push_ent = ent_q;
endmodule

// ----- sv/cwnf_queue.sv -----
// Two-entry queue between the front end and the back end.
module cwnf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cwnf_pkg::note_ent_t push_ent,
	input  logic                pop,
	output cwnf_pkg::note_ent_t pop_ent,
	output logic                full,
	output logic                empty,
	output logic [cwnf_pkg::QCNT_BITS-1:0] count
);
	import cwnf_pkg::*;

	note_ent_t            mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_BITS'(1);
			if (pop)
				rd_q <= rd_q + QPTR_BITS'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_BITS'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ent;
	end

	assign pop_ent = mem_q[rd_q];
	assign full    = cnt_q == QCNT_BITS'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign count   = cnt_q;
endmodule

// ----- sv/cwnf_back.sv -----
// Back end: probe each window copy and deliver kept notes.
module cwnf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cwnf_pkg::cfg_t      cfg,
	input  logic                q_empty,
	input  cwnf_pkg::note_ent_t q_ent,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output cwnf_pkg::tick_t     kept_start,
	output cwnf_pkg::tick_t     kept_end,
	output cwnf_pkg::tag_t      kept_tag
);
	import cwnf_pkg::*;

	back_state_t state_q, state_d;
	note_ent_t   ent_q;
	logic [1:0]  win_q;
	logic        hit_q;
	wide_t       d_q, y_q, k_q;
	logic        ph_q;
	logic        ovalid_q;
	tick_t       kstart_q, kend_q;
	tag_t        ktag_q;

	wide_t s_w, e_w, a_w, l_w, wl_w, lim, aw, lo, hi, x, y, p, k_w;
	logic [2*MW:0] prod;
	logic  wrap_win, win_en, win_live, e_in, done_win, final_hit, out_load;
	logic  mod_start, mod_done;

	// window bounds for the current copy
	always_comb begin
		s_w      = {2'b00, ent_q.s};
		e_w      = {2'b00, ent_q.e};
		a_w      = {2'b00, ent_q.a};
		l_w      = {2'b00, cfg.loop_len};
		wl_w     = {2'b00, cfg.win_len};
		lim      = (e_w <= s_w) ? e_w + l_w : e_w;
		aw       = a_w + wl_w;
		wrap_win = aw > l_w;
		case (win_q)
			2'd0: begin
				lo = a_w; hi = aw; win_en = 1'b1;
			end
			2'd1: begin
				lo = a_w + l_w; hi = aw + l_w; win_en = 1'b1;
			end
			default: begin
				lo = '0; hi = aw - l_w; win_en = wrap_win;
			end
		endcase
		x        = (lo > s_w) ? lo : s_w;
		y        = (hi < lim) ? hi : lim;
		win_live = win_en && (x < y);
		e_in     = (e_w >= a_w && e_w < aw) || (wrap_win && e_w < aw - l_w);
		done_win = hit_q || win_q == 2'd3;
		final_hit = hit_q || e_in;
		out_load = !ovalid_q || !out_stall;
		// probe count up to the window: ceiling of the distance over the step
		prod     = {{(MW+1){1'b0}}, d_q + MW'(PROBE_STEP - 1)} * {{MW{1'b0}}, PROBE_RECIP};
		k_w      = MW'(prod >> PROBE_SHIFT);
		// first probe at or after the window start
		p        = s_w + k_q * MW'(PROBE_STEP);
		mod_done = (state_q == B_MOD) && ph_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty)
					state_d = q_ent.pass ? B_OUT : B_WIN;
			end
			B_WIN: begin
				if (done_win)
					state_d = final_hit ? B_OUT : B_IDLE;
				else if (win_live)
					state_d = B_MOD;
			end
			B_MOD: begin
				if (mod_done)
					state_d = B_WIN;
			end
			B_OUT: begin
				if (out_load)
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		mod_start = 1'b0;
		case (state_q)
			B_IDLE: pop = !q_empty;
			B_WIN:  mod_start = !done_win && win_live;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			win_q    <= 2'd0;
			hit_q    <= 1'b0;
			ph_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= (state_q == B_MOD) && !ph_q;
			if (pop) begin
				win_q <= 2'd0;
				hit_q <= 1'b0;
			end else if (state_q == B_WIN && !done_win && !win_live) begin
				win_q <= win_q + 2'd1;
			end else if (state_q == B_MOD && mod_done) begin
				win_q <= win_q + 2'd1;
				if (p < y_q)
					hit_q <= 1'b1;
			end
			if (state_q == B_OUT && out_load)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
		end
	end

	// hold the popped note, probe bounds and the output register
	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= q_ent;
		if (mod_start) begin
			d_q <= x - s_w;
			y_q <= y;
		end
		if (state_q == B_MOD && !ph_q)
			k_q <= k_w;
		if (state_q == B_OUT && out_load) begin
			kstart_q <= ent_q.ns;
			kend_q   <= ent_q.ne;
			ktag_q   <= ent_q.tag;
		end
	end

	assign out_valid  = ovalid_q;
	assign kept_start = kstart_q;
	assign kept_end   = kend_q;
	assign kept_tag   = ktag_q;
endmodule

// ----- sv/circular_window_note_filter.sv -----
// Top level: configuration registers, front end, queue and back end.
// Flow: the front makes three bit-serial modulo passes by the loop length (start, end and
// window start), then the back probes up to three window copies; pass-all notes skip both
// the modulo passes and the probing.
// The front takes a new note only after it has pushed the last one into the queue.
// Reset: control state clears at once, registers take 1536 / 0 / 384; no clearing pass.
module circular_window_note_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  cwnf_pkg::tick_t     cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  cwnf_pkg::tick_t     note_start,
	input  cwnf_pkg::tick_t     note_end,
	input  cwnf_pkg::tag_t      note_tag,
	output logic                out_valid,
	input  logic                out_stall,
	output cwnf_pkg::tick_t     kept_start,
	output cwnf_pkg::tick_t     kept_end,
	output cwnf_pkg::tag_t      kept_tag
);
	import cwnf_pkg::*;

	cfg_t                 cfg_q;
	logic                 push, pop, q_full, q_empty;
	note_ent_t            push_ent, pop_ent;
	logic [QCNT_BITS-1:0] q_count;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_len  <= TICK_BITS'(1536);
			cfg_q.win_start <= '0;
			cfg_q.win_len   <= TICK_BITS'(384);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOOP:   cfg_q.loop_len  <= cfg_data;
				CFG_WSTART: cfg_q.win_start <= cfg_data;
				CFG_WLEN:   cfg_q.win_len   <= cfg_data;
				default: ;
			endcase
		end
	end

	cwnf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.note_start (note_start),
		.note_end   (note_end),
		.note_tag   (note_tag),
		.push       (push),
		.push_ent   (push_ent),
		.q_full     (q_full)
	);

	cwnf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.full     (q_full),
		.empty    (q_empty),
		.count    (q_count)
	);

	cwnf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_ent      (pop_ent),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kept_start (kept_start),
		.kept_end   (kept_end),
		.kept_tag   (kept_tag)
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_BITS'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the circular window note filter.
`timescale 1ns / 1ps

module tb_top;
	import cwnf_pkg::*;

	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 900000;
	localparam int RANDOM_NOTES = 1100;

	typedef struct packed {
		tick_t ns;
		tick_t ne;
		tag_t  tag;
	} note_t;

	// Directed row: configuration to apply first (when set), note, typed-in verdict
	typedef struct {
		logic  do_cfg;
		tick_t loop_len;
		tick_t win_start;
		tick_t win_len;
		note_t note;
		int    verdict; // 1 keep, 0 drop, -1 from predictor
	} row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [1:0]      cfg_index = CFG_LOOP;
	tick_t           cfg_data = '0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	tick_t           note_start = '0;
	tick_t           note_end = '0;
	tag_t            note_tag = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	tick_t           kept_start;
	tick_t           kept_end;
	tag_t            kept_tag;

	// Predictor copy of the registers
	logic [63:0] loop_reg;
	logic [63:0] wstart_reg;
	logic [63:0] wlen_reg;

	note_t kept_q[$];
	int    mismatches = 0;
	int    notes_sent = 0;
	int    notes_kept = 0;
	int    cycle_count = 0;

	circular_window_note_filter dut (.*);

	always #1 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report(input string what);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Is there a probe s + k*PROBE_STEP inside [lo, hi) and below lim?
	function automatic logic probe_hits(input logic [63:0] s, lim, lo, hi);
		logic [63:0] x, y, k;
		x = (lo > s) ? lo : s;
		y = (hi < lim) ? hi : lim;
		if (x >= y)
			return 1'b0;
		k = (x - s + PROBE_STEP - 1) / PROBE_STEP;
		return (s + k * PROBE_STEP) < y;
	endfunction

	// Decide whether a note overlaps the display window on the loop
	function automatic logic note_in_window(input note_t n);
		logic [63:0] s, e, lim, a;
		if (loop_reg == 0 || wlen_reg == 0)
			return 1'b0;
		if (wlen_reg >= loop_reg)
			return 1'b1;
		s = n.ns % loop_reg;
		e = n.ne % loop_reg;
		lim = (e <= s) ? e + loop_reg : e;
		a = wstart_reg % loop_reg;
		if (probe_hits(s, lim, a, a + wlen_reg))
			return 1'b1;
		if (probe_hits(s, lim, a + loop_reg, a + loop_reg + wlen_reg))
			return 1'b1;
		if (a + wlen_reg > loop_reg && probe_hits(s, lim, 0, a + wlen_reg - loop_reg))
			return 1'b1;
		if (e >= a && e < a + wlen_reg)
			return 1'b1;
		return (a + wlen_reg > loop_reg) && (e < a + wlen_reg - loop_reg);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input tick_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LOOP:   loop_reg   = value;
			CFG_WSTART: wstart_reg = value;
			CFG_WLEN:   wlen_reg   = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until the block has nothing in flight
	task automatic settle();
		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input tick_t l, input tick_t ws, input tick_t wl);
		settle();
		write_reg(CFG_LOOP, l);
		write_reg(CFG_WSTART, ws);
		write_reg(CFG_WLEN, wl);
	endtask

	// Send one note, queue its expected result
	task automatic send_note(input note_t n, input int verdict);
		logic keep;
		keep = note_in_window(n);
		if (verdict >= 0 && keep != verdict[0])
			report($sformatf("predictor verdict %0b differs from table for %h", keep, n));
		repeat ($urandom_range(0, 11)) @(negedge clk);
		@(negedge clk);
		in_valid   <= 1'b1;
		note_start <= n.ns;
		note_end   <= n.ne;
		note_tag   <= n.tag;
		do @(posedge clk); while (in_stall);
		if (keep)
			kept_q.insert(kept_q.size(), n);
		notes_sent++;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Receiver: draw a stall length per result, then wait for the request
	initial begin
		int gap;
		forever begin
			gap = $urandom_range(0, 11);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		note_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (kept_q.size() == 0) begin
				report($sformatf("unexpected note %h %h %h", kept_start, kept_end, kept_tag));
			end else begin
				want = kept_q.pop_front();
				notes_kept++;
				if (kept_start !== want.ns)
					report($sformatf("kept_start %h want %h", kept_start, want.ns));
				if (kept_end !== want.ne)
					report($sformatf("kept_end %h want %h", kept_end, want.ne));
				if (kept_tag !== want.tag)
					report($sformatf("kept_tag %h want %h", kept_tag, want.tag));
			end
		end
	end

	function automatic tick_t rnd_tick();
		case ($urandom_range(0, 3))
			0: return tick_t'($urandom);
			1: return tick_t'($urandom_range(0, 4000));
			2: return tick_t'(tick_t'('1) - $urandom_range(0, 64));
			default: return tick_t'($urandom_range(0, 200));
		endcase
	endfunction

	row_t rows[$];

	initial begin
		note_t n;
		tick_t l, ws, wl;
		int    pick;
		loop_reg   = 1536;
		wstart_reg = 0;
		wlen_reg   = 384;

		// Directed table
		rows = '{
			'{1'b0, 0, 0, 0, '{24'd0, 24'd10, 16'h0001}, 1},
			'{1'b0, 0, 0, 0, '{24'd383, 24'd383, 16'h0002}, 1},
			'{1'b0, 0, 0, 0, '{24'd384, 24'd400, 16'h0003}, 0},
			'{1'b0, 0, 0, 0, '{24'd1500, 24'd10, 16'hFFFF}, 1},
			'{1'b0, 0, 0, 0, '{24'd700, 24'd700, 16'h0004}, 1},
			'{1'b0, 0, 0, 0, '{24'hFFFFFF, 24'hFFFFFF, 16'hA5A5}, -1},
			'{1'b0, 0, 0, 0, '{24'd1536, 24'd1537, 16'h5A5A}, 1},
			'{1'b0, 0, 0, 0, '{24'd385, 24'd1535, 16'h0005}, 0},
			'{1'b1, 0, 0, 100, '{24'd0, 24'd10, 16'h0006}, 0},
			'{1'b1, 24'hFFFFFF, 24'hFFFFFF, 0, '{24'd0, 24'd10, 16'h0007}, 0},
			'{1'b1, 100, 0, 100, '{24'd50, 24'd60, 16'h0008}, 1},
			'{1'b1, 100, 5, 24'hFFFFFF, '{24'hFFFFFF, 24'd0, 16'h0009}, 1},
			'{1'b1, 1000, 950, 100, '{24'd20, 24'd30, 16'h000A}, 1},
			'{1'b1, 1000, 950, 100, '{24'd50, 24'd60, 16'h000B}, 0},
			'{1'b1, 1000, 1950, 100, '{24'd990, 24'd990, 16'h000C}, 1},
			'{1'b1, 1000, 100, 10, '{24'd0, 24'd200, 16'h000D}, -1},
			'{1'b1, 1000, 100, 1, '{24'd76, 24'd200, 16'h000E}, 1},
			'{1'b1, 1000, 100, 1, '{24'd77, 24'd90, 16'h000F}, 0},
			'{1'b1, 24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFE, '{24'h0, 24'h1, 16'h1234}, 1},
			'{1'b1, 24'hFFFFFF, 24'hFFFFFE, 2, '{24'hFFFFFD, 24'h0, 16'h4321}, -1}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].do_cfg)
				set_window(rows[i].loop_len, rows[i].win_start, rows[i].win_len);
			send_note(rows[i].note, rows[i].verdict);
		end

		// Random phases: new window every so often, mostly small loops
		for (int i = 0; i < RANDOM_NOTES; i++) begin
			if (i % 100 == 0) begin
				pick = $urandom_range(0, 9);
				l  = (pick == 0) ? tick_t'($urandom) : tick_t'($urandom_range(1, 3000));
				if (pick == 1)
					l = '1;
				ws = (pick == 2) ? tick_t'($urandom) : tick_t'($urandom_range(0, 2 * l));
				wl = tick_t'($urandom_range(1, l));
				if (pick == 3)
					wl = 0;
				if (pick == 4)
					l = 0;
				set_window(l, ws, wl);
			end
			n.ns  = rnd_tick();
			n.ne  = ($urandom_range(0, 1)) ? tick_t'(n.ns + $urandom_range(0, 300)) : rnd_tick();
			n.tag = tag_t'($urandom);
			send_note(n, -1);
		end

		settle();
		$display("sent %0d notes, %0d passed through the window", notes_sent, notes_kept);
		$display("%0d mismatches over window, loop and wrap-around cases", mismatches);
		if (mismatches == 0 && kept_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/cwnf_pkg.sv
sv/cwnf_mod.sv
sv/cwnf_front.sv
sv/cwnf_queue.sv
sv/cwnf_back.sv
sv/circular_window_note_filter.sv
tb/tb_top.sv
